// ----- rtl/channel_slot_assigner_top_defines.svh -----
// Assertion macros for the channel slot assigner.
`ifndef CHANNEL_SLOT_ASSIGNER_TOP_DEFINES_SVH
`define CHANNEL_SLOT_ASSIGNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Implication check on the block clock, off while in reset.
`define CSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge.
`define CSA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CSA_ASSERT(lbl, prop, msg)
`define CSA_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/csa_pkg.sv -----
// Shared widths, status codes and types of the channel slot assigner.
package csa_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned NEXT_W   = 9;
  localparam int unsigned RATE_W   = 4;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned NODE_W   = 32;
  localparam int unsigned KEY_W    = RATE_W + FREQ_W;

  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KNOWN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

endpackage

// ----- rtl/csa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/csa_scan.sv -----
// Linear table scan: one read issued per cycle, compared in the cycle after it is issued.
module csa_scan #(
  parameter int unsigned IW = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IW-1:0]       limit_i,
  input  logic                hit_i,
  output logic [IW-1:0]       rd_idx_o,
  output logic [IW-1:0]       match_idx_o,
  output csa_pkg::scan_res_t  res_o
);
  import csa_pkg::*;

  logic          act_q, act_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] pidx_q, pidx_d;

  always_comb begin
    act_d  = act_q;
    pv_d   = pv_q;
    idx_d  = idx_q;
    pidx_d = pidx_q;
    res_o  = '0;
    if (act_q) begin
      priority if (pv_q && hit_i) begin
        res_o.done  = 1'b1;
        res_o.found = 1'b1;
        act_d       = 1'b0;
        pv_d        = 1'b0;
      end else if (idx_q < limit_i) begin
        // issue the next entry; its data comes back next cycle
        pv_d   = 1'b1;
        pidx_d = idx_q;
        idx_d  = idx_q + 1'b1;
      end else begin
        pv_d = 1'b0;
        if (!pv_q) begin
          res_o.done = 1'b1;
          act_d      = 1'b0;
        end
      end
    end
    // a new scan may start in the cycle that reports the previous one
    if (start_i) begin
      act_d = 1'b1;
      pv_d  = 1'b0;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      pv_q   <= 1'b0;
      idx_q  <= '0;
      pidx_q <= '0;
    end else begin
      act_q  <= act_d;
      pv_q   <= pv_d;
      idx_q  <= idx_d;
      pidx_q <= pidx_d;
    end
  end

  assign rd_idx_o    = idx_q;
  assign match_idx_o = pidx_q;

endmodule

// ----- rtl/channel_slot_assigner_top.sv -----
// Top level of the channel slot assigner: sequencer, tables and scan unit.
//
// Usage: drive the item fields and raise start_i; the item is taken at a
// rising edge with start_i high and busy_o low. Each item gives one result
// beat: result_valid_o is high for exactly one cycle with status_o, slot_o
// and channel_created_o valid; the receiver cannot hold it off.
// A registration without burst request answers in the cycle after
// acceptance. A query scans the node table. A burst registration scans
// the channel table, then the pair table (known channel only), then the
// node table, stopping once the result is known, one entry per cycle
// through one shared scan unit on the registered read port of each RAM.
// For items that scan, busy_o is high from acceptance until the result
// beat, so one item is in work at a time and reads never overlap the
// write-back of the same entry. Reset clears the three fill counts; tables
// need no clearing pass since only entries below a count are read.
`include "channel_slot_assigner_top_defines.svh"
module channel_slot_assigner_top #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned PAIRS    = 256,
  parameter int unsigned NODES    = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic                          burst_request_i,
  input  logic                          has_phy_tag_i,
  input  logic [csa_pkg::RATE_W-1:0]    data_rate_i,
  input  logic [csa_pkg::FREQ_W-1:0]    frequency_hz_i,
  input  logic [csa_pkg::NODE_W-1:0]    node_id_i,
  output logic                          result_valid_o,
  output logic [csa_pkg::STATUS_W-1:0]  status_o,
  output logic [csa_pkg::SLOT_W-1:0]    slot_o,
  output logic                          channel_created_o
);
  import csa_pkg::*;

  localparam int unsigned CAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PAW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int unsigned NAW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CCW = $clog2(CHANNELS + 1);
  localparam int unsigned PCW = $clog2(PAIRS + 1);
  localparam int unsigned NCW = $clog2(NODES + 1);
  localparam int unsigned IW0 = (CCW > PCW) ? CCW : PCW;
  localparam int unsigned IW  = (IW0 > NCW) ? IW0 : NCW;
  localparam int unsigned CH_W = KEY_W + NEXT_W;
  localparam int unsigned PR_W = CAW + NODE_W;
  localparam int unsigned ND_W = NODE_W + SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAN = 2'd1;
  localparam logic [1:0] S_PAIR = 2'd2;
  localparam logic [1:0] S_NODE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CCW-1:0] chan_count_q, chan_count_d;
  logic [PCW-1:0] pair_count_q, pair_count_d;
  logic [NCW-1:0] node_count_q, node_count_d;

  logic                rv_q, rv_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                cr_q, cr_d;

  logic              query_q, query_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [CAW-1:0]    ch_q, ch_d;
  logic [NEXT_W-1:0] next_q, next_d;
  logic              created_q, created_d;

  // scan unit
  logic          scan_start;
  logic [IW-1:0] scan_limit;
  logic          scan_hit;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] match_idx;
  scan_res_t     scan_res;

  // table ports
  logic            ch_we, pr_we, nd_we;
  logic [CH_W-1:0] ch_wdata, ch_rdata;
  logic [PR_W-1:0] pr_wdata, pr_rdata;
  logic [ND_W-1:0] nd_wdata, nd_rdata;
  logic [NAW-1:0]  nd_waddr;

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);

  csa_ram #(.WIDTH(CH_W), .DEPTH(CHANNELS)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_q),
    .wdata_i (ch_wdata),
    .raddr_i (rd_idx[CAW-1:0]),
    .rdata_o (ch_rdata)
  );

  csa_ram #(.WIDTH(PR_W), .DEPTH(PAIRS)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pair_count_q[PAW-1:0]),
    .wdata_i (pr_wdata),
    .raddr_i (rd_idx[PAW-1:0]),
    .rdata_o (pr_rdata)
  );

  csa_ram #(.WIDTH(ND_W), .DEPTH(NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (nd_waddr),
    .wdata_i (nd_wdata),
    .raddr_i (rd_idx[NAW-1:0]),
    .rdata_o (nd_rdata)
  );

  csa_scan #(.IW(IW)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .limit_i     (scan_limit),
    .hit_i       (scan_hit),
    .rd_idx_o    (rd_idx),
    .match_idx_o (match_idx),
    .res_o       (scan_res)
  );

  always_comb begin
    unique case (state_q)
      S_CHAN: begin
        scan_limit = IW'(chan_count_q);
        scan_hit   = (ch_rdata[CH_W-1:NEXT_W] == key_q);
      end
      S_PAIR: begin
        scan_limit = IW'(pair_count_q);
        scan_hit   = (pr_rdata == {ch_q, node_q});
      end
      S_NODE: begin
        scan_limit = IW'(node_count_q);
        scan_hit   = (nd_rdata[ND_W-1:SLOT_W] == node_q);
      end
      S_IDLE: begin
        scan_limit = '0;
        scan_hit   = 1'b0;
      end
    endcase
  end

  assign ch_wdata = {key_q, next_q + 1'b1};
  assign pr_wdata = {ch_q, node_q};
  assign nd_wdata = {node_q, next_q[SLOT_W-1:0]};
  assign nd_waddr = scan_res.found ? match_idx[NAW-1:0] : node_count_q[NAW-1:0];

  always_comb begin
    state_d      = state_q;
    chan_count_d = chan_count_q;
    pair_count_d = pair_count_q;
    node_count_d = node_count_q;
    rv_d         = 1'b0;
    st_d         = st_q;
    slot_d       = slot_q;
    cr_d         = cr_q;
    query_d      = query_q;
    key_d        = key_q;
    node_d       = node_q;
    ch_d         = ch_q;
    next_d       = next_q;
    created_d    = created_q;
    scan_start   = 1'b0;
    ch_we        = 1'b0;
    pr_we        = 1'b0;
    nd_we        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          query_d = action_i;
          key_d   = has_phy_tag_i ? {data_rate_i, frequency_hz_i} : '0;
          node_d  = node_id_i;
          priority if (action_i) begin
            state_d    = S_NODE;
            scan_start = 1'b1;
          end else if (!burst_request_i) begin
            rv_d   = 1'b1;
            st_d   = ST_IGNORED;
            slot_d = '0;
            cr_d   = 1'b0;
          end else begin
            state_d    = S_CHAN;
            scan_start = 1'b1;
          end
        end
      end
      S_CHAN: begin
        if (scan_res.done) begin
          priority if (scan_res.found) begin
            ch_d       = match_idx[CAW-1:0];
            next_d     = ch_rdata[NEXT_W-1:0];
            created_d  = 1'b0;
            state_d    = S_PAIR;
            scan_start = 1'b1;
          end else if (chan_count_q >= CCW'(CHANNELS)) begin
            rv_d    = 1'b1;
            st_d    = ST_FULL;
            slot_d  = '0;
            cr_d    = 1'b0;
            state_d = S_IDLE;
          end else begin
            ch_d       = chan_count_q[CAW-1:0];
            next_d     = '0;
            created_d  = 1'b1;
            state_d    = S_NODE;
            scan_start = 1'b1;
          end
        end
      end
      S_PAIR: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            rv_d    = 1'b1;
            st_d    = ST_KNOWN;
            slot_d  = '0;
            cr_d    = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d    = S_NODE;
            scan_start = 1'b1;
          end
        end
      end
      S_NODE: begin
        if (scan_res.done) begin
          rv_d    = 1'b1;
          cr_d    = 1'b0;
          slot_d  = '0;
          state_d = S_IDLE;
          priority if (query_q) begin
            if (scan_res.found) begin
              st_d   = ST_HIT;
              slot_d = nd_rdata[SLOT_W-1:0];
            end else begin
              st_d = ST_MISS;
            end
          end else if (pair_count_q >= PCW'(PAIRS) || next_q[NEXT_W-1] ||
                       (!scan_res.found && node_count_q >= NCW'(NODES))) begin
            st_d = ST_FULL;
          end else begin
            // write back all three tables in the same cycle
            ch_we        = 1'b1;
            pr_we        = 1'b1;
            nd_we        = 1'b1;
            pair_count_d = pair_count_q + 1'b1;
            if (created_q) begin
              chan_count_d = chan_count_q + 1'b1;
            end
            if (!scan_res.found) begin
              node_count_d = node_count_q + 1'b1;
            end
            st_d   = ST_NEW;
            slot_d = next_q[SLOT_W-1:0];
            cr_d   = created_q;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chan_count_q <= '0;
      pair_count_q <= '0;
      node_count_q <= '0;
      rv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      chan_count_q <= chan_count_d;
      pair_count_q <= pair_count_d;
      node_count_q <= node_count_d;
      rv_q         <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q      <= st_d;
    slot_q    <= slot_d;
    cr_q      <= cr_d;
    query_q   <= query_d;
    key_q     <= key_d;
    node_q    <= node_d;
    ch_q      <= ch_d;
    next_q    <= next_d;
    created_q <= created_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign result_valid_o    = rv_q;
  assign status_o          = st_q;
  assign slot_o            = slot_q;
  assign channel_created_o = cr_q;

  `CSA_ASSERT(a_accept_progress, (start_i && !busy_o) |=> (busy_o || result_valid_o),
              "accepted item neither in work nor answered")
  `CSA_ASSERT(a_slot_only_on_grant,
              (result_valid_o && slot_o != '0) |-> (status_o == ST_NEW || status_o == ST_HIT),
              "nonzero slot on a beat that carries no slot")
  `CSA_ASSERT(a_created_only_new, (result_valid_o && channel_created_o) |-> (status_o == ST_NEW),
              "channel created flag without a new slot")
  `CSA_NEVER(a_count_bounds,
             chan_count_q > CCW'(CHANNELS) || pair_count_q > PCW'(PAIRS) ||
             node_count_q > NCW'(NODES),
             "table fill count above its depth")

endmodule
